// ===== rtl/chit_pkg.sv =====
// ----------------------------------------------------------------------------
// chit_pkg: shared types and constants for the chained hash id table
// Operation and status codes, hash constants and the payload structs.
// ----------------------------------------------------------------------------
package chit_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int unsigned MIX_S1 = 30;
	localparam int unsigned MIX_S2 = 27;
	localparam int unsigned MIX_S3 = 31;

	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned COUNT_W  = 7;

	typedef struct packed {
		logic [1:0]          op;
		logic [63:0]         key;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [COUNT_W-1:0]  live_count;
	} rsp_t;

endpackage

// ===== rtl/chit_front.sv =====
// ----------------------------------------------------------------------------
// chit_front: request intake and key hashing
// Takes one request at a time, runs the mixer using one 32x32 multiplier,
// and passes the request with its hash to the back part.
// ----------------------------------------------------------------------------
module chit_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  chit_pkg::req_t     req,
	output logic               hvalid,
	input  logic               hready,
	output chit_pkg::req_t     hreq,
	output logic [63:0]        hash
);
	import chit_pkg::*;

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_CLR  = 4'd1;
	localparam logic [3:0] F_LL   = 4'd2;
	localparam logic [3:0] F_LH   = 4'd3;
	localparam logic [3:0] F_HL   = 4'd4;
	localparam logic [3:0] F_SUM  = 4'd5;
	localparam logic [3:0] F_MID  = 4'd6;
	localparam logic [3:0] F_END  = 4'd7;
	localparam logic [3:0] F_DONE = 4'd9;

	logic [3:0]  step_q;
	req_t        req_q;
	logic [63:0] v_q;
	logic [63:0] c_q;
	logic [63:0] acc_q;
	logic [63:0] pp_q;
	logic [31:0] ma, mb;
	logic [63:0] prod;

	assign full   = (step_q != F_IDLE);
	assign hvalid = (step_q == F_DONE);
	assign hreq   = req_q;
	assign hash   = v_q;

	// select partial product operands per step
	always_comb begin
		case (step_q)
			F_LL:    begin ma = v_q[31:0];  mb = c_q[31:0];  end
			F_LH:    begin ma = v_q[31:0];  mb = c_q[63:32]; end
			F_HL:    begin ma = v_q[63:32]; mb = c_q[31:0];  end
			default: begin ma = 32'd0;      mb = 32'd0;      end
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);

	// step through xor-shift, multiply, xor-shift, multiply, xor-shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= F_IDLE;
		end else begin
			case (step_q)
				F_IDLE: if (push) step_q <= F_CLR;
				F_SUM:  step_q <= (c_q == MIX_C1) ? F_MID : F_END;
				F_MID:  step_q <= F_LL;
				F_END:  step_q <= F_DONE;
				F_DONE: if (hready) step_q <= F_IDLE;
				default: step_q <= step_q + 4'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			F_IDLE: if (push) begin
				req_q <= req;
				v_q   <= req.key ^ (req.key >> MIX_S1);
				c_q   <= MIX_C1;
			end
			F_CLR: acc_q <= 64'd0;
			F_LL:  acc_q <= prod;
			F_LH:  pp_q  <= {prod[31:0], 32'd0};
			F_HL:  acc_q <= acc_q + pp_q + {prod[31:0], 32'd0};
			F_SUM: v_q   <= acc_q;
			F_MID: begin
				v_q <= v_q ^ (v_q >> MIX_S2);
				c_q <= MIX_C2;
			end
			F_END: v_q <= v_q ^ (v_q >> MIX_S3);
			default: ;
		endcase
	end

endmodule

// ===== rtl/chit_fifo.sv =====
// ----------------------------------------------------------------------------
// chit_fifo: two-entry queue between the front and back parts
// Holds hashed requests so that each side stalls on its own.
// ----------------------------------------------------------------------------
module chit_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	output logic             wready,
	input  logic [WIDTH-1:0] wdata,
	output logic             rvalid,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign wready = (cnt_q != 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign rdata  = mem_q[rp_q];

	// advance pointers on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && wready) wp_q <= ~wp_q;
			if (rd && rvalid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && wready) - 2'(rd && rvalid);
		end
	end

	always_ff @(posedge clk) begin
		if (wr && wready) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== rtl/chit_back.sv =====
// ----------------------------------------------------------------------------
// chit_back: chain walker and table update
// Walks a bucket's chain entry by entry through the pool memories, then
// applies insert or remove and queues the response.
// ----------------------------------------------------------------------------
module chit_back #(
	parameter int unsigned BUCKETS     = 64,
	parameter int unsigned ENTRIES     = 64,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           qvalid,
	output logic           qrd,
	input  chit_pkg::req_t qreq,
	input  logic [63:0]    qhash,
	output logic           empty,
	input  logic           pop,
	output chit_pkg::rsp_t rsp
);
	import chit_pkg::*;

	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned EW = $clog2(ENTRIES);
	localparam int unsigned LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);
	localparam int unsigned HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int unsigned NCLR = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int unsigned CW = $clog2(NCLR + 1);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_HEAD  = 3'd1;
	localparam logic [2:0] B_READ  = 3'd2;
	localparam logic [2:0] B_CMP   = 3'd3;
	localparam logic [2:0] B_APPLY = 3'd4;
	localparam logic [2:0] B_OUT   = 3'd5;

	logic [2:0]    st_q;
	req_t          req_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [LW-1:0] steps_q;
	logic          hit_q;
	logic [LW-1:0] free_top_q;
	logic [LW-1:0] total_q;
	logic [LW-1:0] rs_cnt_q;
	logic [1:0]          rs_status_q;
	logic [HANDLE_W-1:0] rs_hout_q;

	// memories
	logic [LW-1:0]       head_m [BUCKETS];
	logic [63:0]         key_m  [ENTRIES];
	logic [HANDLE_W-1:0] hdl_m  [ENTRIES];
	logic [LW-1:0]       link_m [ENTRIES];
	logic [EW-1:0]       fstk_m [ENTRIES];

	logic [LW-1:0]       head_rd;
	logic [63:0]         key_rd;
	logic [HANDLE_W-1:0] hdl_rd;
	logic [LW-1:0]       link_rd;
	logic [EW-1:0]       fstk_rd;

	logic          clr_busy;
	logic [CW-1:0] clr_cnt_q;

	rsp_t rsp_q;
	logic rvalid_q;

	logic [BW-1:0]       bkt_sel;
	logic                do_ins, do_rem, out_go;
	logic [1:0]          ap_status;
	logic [HANDLE_W-1:0] ap_hout;
	logic [LW-1:0]       ap_cnt;

	assign empty    = !rvalid_q;
	assign rsp      = rsp_q;
	assign clr_busy = (clr_cnt_q != CW'(NCLR));
	assign qrd      = (st_q == B_IDLE) && !clr_busy && qvalid;
	assign out_go   = (st_q == B_OUT) && (!rvalid_q || pop);

	// bucket of the incoming request while idle, else the current one
	assign bkt_sel = (st_q == B_IDLE) ? BW'(qhash & 64'(BUCKETS - 1)) : bkt_q;

	logic [EW-1:0] cur_idx;
	assign cur_idx = cur_q[EW-1:0];
	logic [EW-1:0] ftop_idx;
	assign ftop_idx = EW'(free_top_q - LW'(1));

	assign do_ins = (req_q.op == OP_INSERT) && !hit_q && (free_top_q != '0);
	assign do_rem = (req_q.op == OP_REMOVE) && hit_q;
	assign ap_cnt = do_ins ? total_q + LW'(1) :
		(do_rem && total_q != '0) ? total_q - LW'(1) : total_q;

	// form the response of the current request
	always_comb begin
		ap_status = ST_NOT_FOUND;
		ap_hout   = '0;
		case (req_q.op)
			OP_INSERT: begin
				if (hit_q) ap_status = ST_DUPLICATE;
				else if (free_top_q == '0) ap_status = ST_FULL;
				else ap_status = ST_OK;
			end
			OP_FIND: if (hit_q) begin
				ap_status = ST_OK;
				ap_hout   = hdl_rd;
			end
			OP_REMOVE: if (hit_q) begin
				ap_status = ST_OK;
				ap_hout   = hdl_rd;
			end
			default: ;
		endcase
	end

	// registered reads
	always_ff @(posedge clk) begin
		head_rd <= head_m[bkt_sel];
		key_rd  <= key_m[cur_idx];
		hdl_rd  <= hdl_m[cur_idx];
		link_rd <= link_m[cur_idx];
		fstk_rd <= fstk_m[ftop_idx];
	end

	// control and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			free_top_q <= NIL;
			total_q    <= '0;
			rvalid_q   <= 1'b0;
			clr_cnt_q  <= '0;
		end else begin
			if (clr_busy) clr_cnt_q <= clr_cnt_q + CW'(1);
			rvalid_q <= out_go || (rvalid_q && !pop);
			case (st_q)
				B_IDLE: if (qrd) st_q <= B_HEAD;
				B_HEAD: st_q <= B_READ;
				B_READ: st_q <= (cur_q == NIL || steps_q == NIL) ? B_APPLY : B_CMP;
				B_CMP:  st_q <= (key_rd == req_q.key) ? B_APPLY : B_READ;
				B_APPLY: begin
					if (do_ins) begin
						free_top_q <= free_top_q - LW'(1);
						total_q    <= total_q + LW'(1);
					end
					if (do_rem) begin
						if (free_top_q < NIL) free_top_q <= free_top_q + LW'(1);
						if (total_q != '0) total_q <= total_q - LW'(1);
					end
					st_q <= B_OUT;
				end
				B_OUT: if (out_go) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// datapath and memory writes
	always_ff @(posedge clk) begin
		// fill the free-slot stack and empty the bucket heads after reset
		if (clr_busy) begin
			if (clr_cnt_q < CW'(ENTRIES))
				fstk_m[clr_cnt_q[EW-1:0]] <= clr_cnt_q[EW-1:0];
			if (clr_cnt_q < CW'(BUCKETS))
				head_m[clr_cnt_q[BW-1:0]] <= NIL;
		end
		case (st_q)
			B_IDLE: if (qrd) begin
				req_q   <= qreq;
				bkt_q   <= bkt_sel;
				prev_q  <= NIL;
				steps_q <= '0;
				hit_q   <= 1'b0;
			end
			B_HEAD: cur_q <= head_rd;
			B_CMP: begin
				if (key_rd == req_q.key) begin
					hit_q <= 1'b1;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + LW'(1);
				end
			end
			B_APPLY: begin
				if (do_ins) begin
					key_m[fstk_rd]  <= req_q.key;
					hdl_m[fstk_rd]  <= HANDLE_W'(req_q.handle_in[HB-1:0]);
					link_m[fstk_rd] <= head_rd;
					head_m[bkt_q]   <= LW'(fstk_rd);
				end
				if (do_rem) begin
					if (prev_q != NIL) link_m[prev_q[EW-1:0]] <= link_rd;
					else head_m[bkt_q] <= link_rd;
					link_m[cur_idx] <= NIL;
					if (free_top_q < NIL) fstk_m[free_top_q[EW-1:0]] <= cur_idx;
				end
				rs_status_q <= ap_status;
				rs_hout_q   <= ap_hout;
				rs_cnt_q    <= ap_cnt;
			end
			// load the result register once the previous result has gone
			B_OUT: if (out_go) begin
				rsp_q <= '{status: rs_status_q, handle_out: rs_hout_q,
					live_count: COUNT_W'(rs_cnt_q)};
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= NIL) else $error("live count above pool size");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		(free_top_q + total_q) == NIL) else $error("free and live counts disagree");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		qrd |-> st_q == B_IDLE && !clr_busy) else $error("request taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("waiting response changed");
`endif

endmodule

// ===== rtl/chained_hash_id_table_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_id_table_core: key-to-handle map with chained hash buckets
// Top level joining the hashing front, the queue and the chain walker.
// ----------------------------------------------------------------------------
// A request passes through the front's hashing steps, the queue and the
// back's head read, then a read and a compare for each chain entry until the
// key is found or the chain ends; its result reaches the result ports once
// the previous result has been popped. The hash uses one shared 32x32
// multiplier, three partial products per multiply, so the front takes one
// request at a time; it hashes the next request while the back walks a chain.
// After reset the free-slot stack and bucket heads are initialised before
// the first request is walked.
module chained_hash_id_table_core #(
	parameter int unsigned BUCKETS     = 64,
	parameter int unsigned ENTRIES     = 64,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  chit_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output chit_pkg::rsp_t rsp
);
	import chit_pkg::*;

	localparam int unsigned QW = $bits(req_t) + 64;

	logic        hvalid, hready, qvalid, qrd;
	req_t        hreq, qreq;
	logic [63:0] hash, qhash;

	chit_front u_front (
		.clk, .arst_n, .push, .full, .req,
		.hvalid, .hready, .hreq, .hash
	);

	chit_fifo #(.WIDTH(QW)) u_fifo (
		.clk, .arst_n,
		.wr(hvalid), .wready(hready), .wdata({hreq, hash}),
		.rvalid(qvalid), .rd(qrd), .rdata({qreq, qhash})
	);

	chit_back #(
		.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk, .arst_n, .qvalid, .qrd, .qreq, .qhash, .empty, .pop, .rsp
	);

endmodule

// ===== test/chained_hash_id_table_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_id_table_core_test: self-checking bench for the hash id table
// Feeds insert, find and remove requests through the queue-style ports and
// compares each response with a behavioural copy of the table kept here.
// ----------------------------------------------------------------------------
module chained_hash_id_table_core_test;
	import chit_pkg::*;

	localparam int unsigned NB   = 64;
	localparam int unsigned NE   = 64;
	localparam int unsigned NULL_SLOT = NE;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t req;
	logic empty;
	logic pop;
	rsp_t rsp;

	chained_hash_id_table_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	// Shadow copy of the table
	int unsigned   shadow_head[NB];
	logic [63:0]   shadow_key[NE];
	logic [15:0]   shadow_handle[NE];
	int unsigned   shadow_link[NE];
	int unsigned   shadow_free[NE];
	int unsigned   shadow_top;
	int unsigned   shadow_live;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	logic [63:0] live_keys[$];

	int  mismatches;
	int  idle_cycles;
	bit  rx_hold;
	bit  tx_taken;
	bit  rx_taken;
	int  tx_wait;
	int  rx_wait;
	int  rx_gap;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] mix64(input logic [63:0] v);
		v = v ^ (v >> MIX_S1);
		v = v * MIX_C1;
		v = v ^ (v >> MIX_S2);
		v = v * MIX_C2;
		v = v ^ (v >> MIX_S3);
		return v;
	endfunction

	// Walk a chain; return the slot holding the key or the null marker
	function automatic int unsigned chain_find(input int unsigned b,
		input logic [63:0] k, output int unsigned prev);
		int unsigned cur;
		int unsigned steps;
		cur = shadow_head[b];
		prev = NULL_SLOT;
		for (steps = 0; steps < NE && cur < NE; steps++) begin
			if (shadow_key[cur] == k)
				return cur;
			prev = cur;
			cur = shadow_link[cur];
		end
		prev = NULL_SLOT;
		return NULL_SLOT;
	endfunction

	// Apply one request to the shadow table and queue its response
	function automatic void table_apply(input req_t r);
		rsp_t        o;
		int unsigned b;
		int unsigned hit;
		int unsigned prev;
		int unsigned slot;
		o.status = ST_NOT_FOUND;
		o.handle_out = '0;
		b = 32'(mix64(r.key) & 64'(NB - 1));
		hit = chain_find(b, r.key, prev);
		case (r.op)
			OP_INSERT: begin
				if (hit < NE) begin
					o.status = ST_DUPLICATE;
				end else if (shadow_top == 0) begin
					o.status = ST_FULL;
				end else begin
					shadow_top--;
					slot = shadow_free[shadow_top];
					shadow_key[slot] = r.key;
					shadow_handle[slot] = r.handle_in;
					shadow_link[slot] = shadow_head[b];
					shadow_head[b] = slot;
					shadow_live++;
					o.status = ST_OK;
				end
			end
			OP_FIND: begin
				if (hit < NE) begin
					o.status = ST_OK;
					o.handle_out = shadow_handle[hit];
				end
			end
			OP_REMOVE: begin
				if (hit < NE) begin
					if (prev < NE)
						shadow_link[prev] = shadow_link[hit];
					else
						shadow_head[b] = shadow_link[hit];
					shadow_link[hit] = NULL_SLOT;
					o.handle_out = shadow_handle[hit];
					if (shadow_top < NE) begin
						shadow_free[shadow_top] = hit;
						shadow_top++;
					end
					if (shadow_live > 0)
						shadow_live--;
					o.status = ST_OK;
				end
			end
			default: ;
		endcase
		o.live_count = shadow_live[COUNT_W-1:0];
		expected_rsps.push_back(o);
	endfunction

	// Pick a key: mostly from a small pool so chains and hits happen often
	function automatic logic [63:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && live_keys.size() > 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		if (sel < 8)
			return 64'(1000 + $urandom_range(0, 90));
		return {$urandom, $urandom};
	endfunction

	function automatic void add_req(input logic [1:0] o, input logic [63:0] k,
		input logic [15:0] h);
		req_t r;
		r.op = o;
		r.key = k;
		r.handle_in = h;
		pending_reqs.push_back(r);
		if (o == OP_INSERT && live_keys.size() < 200)
			live_keys.push_back(k);
	endfunction

	// Sender pause marker: a pending item with the spare op and key all ones
	// is a barrier, held until the response queue drains
	function automatic bit stim_hold();
		if (pending_reqs.size() == 0)
			return 1'b0;
		if (pending_reqs[0].op == OP_SPARE && pending_reqs[0].key == '1) begin
			if (expected_rsps.size() == 0)
				void'(pending_reqs.pop_front());
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Record the transactions taken at each rising edge
	always @(posedge clk) begin
		tx_taken <= push && !full;
		rx_taken <= pop && !empty;
	end

	// Driver: offer pending requests with random gaps, change on falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || tx_taken) begin
			if (tx_wait > 0) begin
				tx_wait <= tx_wait - 1;
				push <= 1'b0;
			end else if (pending_reqs.size() > 0 && !stim_hold()) begin
				req <= pending_reqs.pop_front();
				push <= 1'b1;
				tx_wait <= $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				table_apply(req);
			if (pop && !empty) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response %p", rsp);
				end else if (rsp !== expected_rsps[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", expected_rsps[0], rsp);
					void'(expected_rsps.pop_front());
				end else begin
					void'(expected_rsps.pop_front());
				end
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random pop gaps, plus a long hold requested by rx_hold
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait <= 0;
		end else if (rx_hold) begin
			pop <= 1'b0;
		end else if (pop && rx_taken) begin
			rx_gap = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
			rx_wait <= rx_gap;
			pop <= (rx_gap == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Long receiver stall while the sender keeps offering
	initial begin
		int n;
		rx_hold = 1'b0;
		wait (arst_n);
		repeat (300) @(negedge clk);
		rx_hold = 1'b1;
		for (n = 0; n < 600; n++)
			@(negedge clk);
		rx_hold = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("chained_hash_id_table_core_test NOT OK");
			$finish;
		end
	end

	initial begin
		int   i;
		req_t barrier;
		barrier.op = OP_SPARE;
		barrier.key = '1;
		barrier.handle_in = '0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		req = '0;
		mismatches = 0;
		idle_cycles = 0;
		tx_wait = 0;
		shadow_top = NE;
		shadow_live = 0;
		for (i = 0; i < NB; i++)
			shadow_head[i] = NULL_SLOT;
		for (i = 0; i < NE; i++) begin
			shadow_key[i] = '0;
			shadow_handle[i] = '0;
			shadow_link[i] = NULL_SLOT;
			shadow_free[i] = i;
		end

		// Directed: empty table lookups, extremes, duplicate, unused op
		add_req(OP_FIND, 64'd0, 16'hffff);
		add_req(OP_REMOVE, '1, 16'd0);
		add_req(OP_INSERT, 64'd0, 16'hffff);
		add_req(OP_INSERT, '1, 16'h0000);
		add_req(OP_INSERT, 64'h5555_aaaa_5555_aaaa, 16'h5a5a);
		add_req(OP_INSERT, 64'haaaa_5555_aaaa_5555, 16'ha5a5);
		add_req(OP_INSERT, 64'd0, 16'h1234);
		add_req(OP_FIND, 64'd0, 16'd0);
		add_req(OP_FIND, '1, 16'hffff);
		add_req(OP_SPARE, 64'd0, 16'hffff);
		add_req(OP_REMOVE, 64'd0, 16'd0);
		add_req(OP_REMOVE, 64'd0, 16'd0);
		add_req(OP_FIND, 64'h5555_aaaa_5555_aaaa, 16'd0);
		add_req(OP_REMOVE, '1, 16'd0);
		add_req(OP_REMOVE, 64'h5555_aaaa_5555_aaaa, 16'd0);
		add_req(OP_REMOVE, 64'haaaa_5555_aaaa_5555, 16'd0);
		pending_reqs.push_back(barrier);
		live_keys.delete();

		// Fill the pool past capacity, then hit full and drain it
		for (i = 0; i < 66; i++)
			add_req(OP_INSERT, 64'(5000 + i), 16'($urandom));
		add_req(OP_INSERT, 64'd5000, 16'd1);
		for (i = 0; i < 66; i++)
			add_req(OP_FIND, 64'(5000 + i), 16'd0);
		for (i = 65; i >= 0; i--)
			add_req(OP_REMOVE, 64'(5000 + i), 16'd0);
		live_keys.delete();

		// Random mix
		for (i = 0; i < 1500; i++) begin
			int unsigned o;
			o = $urandom_range(0, 19);
			add_req(o < 8 ? OP_INSERT : o < 13 ? OP_FIND : o < 19 ? OP_REMOVE : OP_SPARE,
				pick_key(), 16'($urandom));
			if (i == 700)
				pending_reqs.push_back(barrier);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !push);
		wait (expected_rsps.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("chained_hash_id_table_core_test OK");
		else
			$display("chained_hash_id_table_core_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/chit_pkg.sv
rtl/chit_front.sv
rtl/chit_fifo.sv
rtl/chit_back.sv
rtl/chained_hash_id_table_core.sv
test/chained_hash_id_table_core_test.sv
